FILE: sv/evith_pkg.sv
// Shared types and constants of the Ethernet/VLAN/IPv4/TCP header parser.
package evith_pkg;

	localparam int MAX_FRAME = 2048;
	localparam int MIN_FRAME = 42;
	// Holds the byte count up to MAX_FRAME + 2 (saturated position plus one).
	localparam int POS_W     = $clog2(MAX_FRAME + 3);

	localparam logic [15:0] TPID_VLAN  = 16'h8100;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [5:0]  HDR_MIN    = 6'd20;

	localparam logic [POS_W-1:0] L3_UNTAGGED = POS_W'(14);
	localparam logic [POS_W-1:0] L3_TAGGED   = POS_W'(18);

	localparam logic [2:0] KIND_DROP         = 3'd0;
	localparam logic [2:0] KIND_UDP_UNTAGGED = 3'd1;
	localparam logic [2:0] KIND_UDP_TAGGED   = 3'd2;
	localparam logic [2:0] KIND_TCP_UNTAGGED = 3'd3;
	localparam logic [2:0] KIND_TCP_TAGGED   = 3'd4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  frame_kind;
		logic [11:0] vlan_id;
		logic [2:0]  vlan_prio;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] port_pair;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [7:0]  tcp_flags;
		logic [15:0] window_size;
		logic [10:0] payload_offset;
		logic [10:0] payload_size;
	} out_item_t;

	// Header fields gathered over one frame.
	typedef struct packed {
		logic [15:0] outer_type;
		logic [15:0] tag_control;
		logic        has_tag;
		logic [15:0] inner_type;
		logic [5:0]  ip_hdr_bytes;
		logic [15:0] ip_length;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] port_pair;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [3:0]  data_offset;
		logic [7:0]  tcp_flags;
		logic [15:0] window_size;
	} frame_state_t;

endpackage

FILE: sv/eth_vlan_ipv4_tcp_header_parser.sv
// Top level: byte-wide Ethernet/802.1Q/IPv4/TCP receive header parser.
// Throughput: one frame byte per cycle while byte_ready is high; it is low while
// a last byte waits in the snapshot slot for a held result register. Field
// capture feeds a frame snapshot register; verdict logic feeds the result register.
// Reset (arst_n low, asynchronous) clears the running frame state, udp_mode
// and both valid flags; snapshot and result payloads are not reset.
module eth_vlan_ipv4_tcp_header_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  evith_pkg::in_item_t  byte_item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output evith_pkg::out_item_t result_item,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	localparam logic [evith_pkg::POS_W-1:0] POS_MAX = evith_pkg::POS_W'(evith_pkg::MAX_FRAME);
	localparam logic [evith_pkg::POS_W-1:0] LEN_MIN = evith_pkg::POS_W'(evith_pkg::MIN_FRAME);

	// Configuration
	logic udp_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udp_mode_q <= 1'b0;
		end else if (cfg_we) begin
			udp_mode_q <= cfg_wdata;
		end
	end

	// Handshake bookkeeping. Only a frame's last byte needs the snapshot
	// slot, which drains whenever the result register is free.
	logic snap_valid_s1;
	logic out_load;
	logic byte_take;

	assign out_load   = snap_valid_s1 && (!result_valid || result_ready);
	assign byte_ready = !snap_valid_s1 || out_load;
	assign byte_take  = byte_valid && byte_ready;

	// Running frame state and byte position
	evith_pkg::frame_state_t          st_q, st_nxt;
	logic [evith_pkg::POS_W-1:0]      pos_q;
	logic [evith_pkg::POS_W-1:0]      l3_cur;
	logic [evith_pkg::POS_W-1:0]      r_off;
	logic [evith_pkg::POS_W-1:0]      t_off;
	logic [7:0]                       b;

	assign b      = byte_item.frame_byte;
	assign l3_cur = st_q.has_tag ? evith_pkg::L3_TAGGED : evith_pkg::L3_UNTAGGED;
	assign r_off  = pos_q - l3_cur;

	// Field capture for the byte at pos_q. The IP header length written at
	// the first L3 byte already steers where that same byte lands.
	always_comb begin
		st_nxt = st_q;
		t_off  = r_off - evith_pkg::POS_W'(st_q.ip_hdr_bytes);
		if (pos_q == evith_pkg::POS_W'(12) || pos_q == evith_pkg::POS_W'(13)) begin
			st_nxt.outer_type = {st_q.outer_type[7:0], b};
		end
		if (pos_q == evith_pkg::POS_W'(13)) begin
			st_nxt.has_tag = ({st_q.outer_type[7:0], b} == evith_pkg::TPID_VLAN);
		end
		if (pos_q >= evith_pkg::L3_UNTAGGED) begin
			if (st_q.has_tag) begin
				if (pos_q inside {[14:15]}) begin
					st_nxt.tag_control = {st_q.tag_control[7:0], b};
				end
				if (pos_q inside {[16:17]}) begin
					st_nxt.inner_type = {st_q.inner_type[7:0], b};
				end
			end
			if (pos_q >= l3_cur) begin
				// IPv4 header
				if (r_off == '0) begin
					st_nxt.ip_hdr_bytes = {b[3:0], 2'b00};
				end else if (r_off inside {[2:3]}) begin
					st_nxt.ip_length = {st_q.ip_length[7:0], b};
				end else if (r_off == evith_pkg::POS_W'(9)) begin
					st_nxt.protocol = b;
				end else if (r_off inside {[12:15]}) begin
					st_nxt.src_ip = {st_q.src_ip[23:0], b};
				end else if (r_off inside {[16:19]}) begin
					st_nxt.dst_ip = {st_q.dst_ip[23:0], b};
				end
				t_off = r_off - evith_pkg::POS_W'(st_nxt.ip_hdr_bytes);
				// TCP header
				if (r_off >= evith_pkg::POS_W'(st_nxt.ip_hdr_bytes)) begin
					if (t_off inside {[0:3]}) begin
						st_nxt.port_pair = {st_q.port_pair[23:0], b};
					end else if (t_off inside {[4:7]}) begin
						st_nxt.seq_number = {st_q.seq_number[23:0], b};
					end else if (t_off inside {[8:11]}) begin
						st_nxt.ack_number = {st_q.ack_number[23:0], b};
					end else if (t_off == evith_pkg::POS_W'(12)) begin
						st_nxt.data_offset = b[7:4];
					end else if (t_off == evith_pkg::POS_W'(13)) begin
						st_nxt.tcp_flags = b;
					end else if (t_off inside {[14:15]}) begin
						st_nxt.window_size = {st_q.window_size[7:0], b};
					end
				end
			end
		end
	end

	// Frame snapshot: a last byte hands its finished fields over and the
	// running state starts clean for the next frame in the same cycle.
	evith_pkg::frame_state_t     snap_s1;
	logic [evith_pkg::POS_W-1:0] len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			pos_q         <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			// a new last byte refills the slot in the cycle it drains
			if (byte_take && byte_item.last_byte) begin
				snap_valid_s1 <= 1'b1;
			end else if (out_load) begin
				snap_valid_s1 <= 1'b0;
			end
			if (byte_take) begin
				if (byte_item.last_byte) begin
					st_q  <= '0;
					pos_q <= '0;
				end else begin
					st_q <= st_nxt;
					if (pos_q <= POS_MAX) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take && byte_item.last_byte) begin
			snap_s1 <= st_nxt;
			len_s1  <= pos_q + 1'b1;
		end
	end

	// Verdict on the snapshot
	logic [evith_pkg::POS_W-1:0] l3_v;
	logic [evith_pkg::POS_W-1:0] avail;
	logic [evith_pkg::POS_W-1:0] total;
	logic [evith_pkg::POS_W-1:0] tp_len;
	logic [evith_pkg::POS_W-1:0] ihb_v;
	logic [evith_pkg::POS_W-1:0] doff_v;
	logic [15:0]                 etype;
	logic                        base_ok;
	logic                        tcp_ok;
	evith_pkg::out_item_t        verdict;

	assign l3_v   = snap_s1.has_tag ? evith_pkg::L3_TAGGED : evith_pkg::L3_UNTAGGED;
	assign etype  = snap_s1.has_tag ? snap_s1.inner_type : snap_s1.outer_type;
	assign ihb_v  = evith_pkg::POS_W'(snap_s1.ip_hdr_bytes);
	assign doff_v = evith_pkg::POS_W'({snap_s1.data_offset, 2'b00});
	assign avail  = len_s1 - l3_v;
	// IP total length clamped to the bytes present after the L2 header
	assign total  = (snap_s1.ip_length < 16'(avail)) ?
		snap_s1.ip_length[evith_pkg::POS_W-1:0] : avail;
	assign tp_len = total - ihb_v;

	assign base_ok = (len_s1 >= LEN_MIN) && (len_s1 <= POS_MAX) &&
		(etype == evith_pkg::ETYPE_IPV4) && (snap_s1.ip_hdr_bytes >= evith_pkg::HDR_MIN);
	assign tcp_ok  = (snap_s1.protocol == evith_pkg::PROTO_TCP) && (total >= ihb_v) &&
		(tp_len >= evith_pkg::POS_W'(evith_pkg::HDR_MIN)) &&
		(doff_v >= evith_pkg::POS_W'(evith_pkg::HDR_MIN)) && (doff_v <= tp_len);

	always_comb begin
		verdict = '0;
		if (base_ok) begin
			if (snap_s1.protocol == evith_pkg::PROTO_UDP && udp_mode_q) begin
				verdict.frame_kind = snap_s1.has_tag ? evith_pkg::KIND_UDP_TAGGED :
					evith_pkg::KIND_UDP_UNTAGGED;
			end else if (tcp_ok) begin
				verdict.frame_kind     = snap_s1.has_tag ? evith_pkg::KIND_TCP_TAGGED :
					evith_pkg::KIND_TCP_UNTAGGED;
				verdict.port_pair      = snap_s1.port_pair;
				verdict.seq_number     = snap_s1.seq_number;
				verdict.ack_number     = snap_s1.ack_number;
				verdict.tcp_flags      = snap_s1.tcp_flags;
				verdict.window_size    = snap_s1.window_size;
				verdict.payload_offset = 11'(l3_v + ihb_v + doff_v);
				verdict.payload_size   = 11'(tp_len - doff_v);
			end
			if (verdict.frame_kind != evith_pkg::KIND_DROP) begin
				if (snap_s1.has_tag) begin
					verdict.vlan_id   = snap_s1.tag_control[11:0];
					verdict.vlan_prio = snap_s1.tag_control[15:13];
				end
				verdict.src_ip = snap_s1.src_ip;
				verdict.dst_ip = snap_s1.dst_ip;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_item <= verdict;
		end
	end

endmodule
